FILE: hdl/nod_pkg.sv
// ============================================================================
// nod_pkg
// Types, widths and codes shared by the nearest obstacle distance unit.
// ============================================================================
package nod_pkg;

    // Grid store geometry.
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int X_W   = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int Y_W   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int H_W   = $clog2(MAX_HEIGHT + 1);
    localparam int ADDR_W = X_W + Y_W;

    // Field widths fixed by the interface.
    localparam int CRD_IN_W = 8;
    localparam int ODDS_W   = 8;
    localparam int GRID_W   = 9;
    localparam int CS_W     = 10;
    localparam int CFG_W    = 10;
    localparam int DIST_W   = 19;

    // Distance arithmetic widths.
    localparam int XY_MAX_W = (X_W > Y_W) ? X_W : Y_W;
    localparam int CRD_W    = (XY_MAX_W > CRD_IN_W) ? XY_MAX_W : CRD_IN_W;
    localparam int SQ_W     = 2 * CRD_W;
    localparam int SUM_W    = SQ_W + 1;
    localparam int CS2_W    = 2 * CS_W;
    localparam int PROD_W   = CS2_W + SUM_W;
    localparam int ROOT_W   = (PROD_W + 1) / 2;
    localparam int RAD_W    = 2 * ROOT_W;
    localparam int REM_W    = ROOT_W + 2;
    localparam int CNT_W    = $clog2(ROOT_W + 1);

    localparam int unsigned NO_OBSTACLE_MM = 99000;
    localparam int unsigned DIST_MAX       = 524287;

    // Register reset values.
    localparam logic [GRID_W-1:0]        GRID_WIDTH_RST  = GRID_W'(256);
    localparam logic [GRID_W-1:0]        GRID_HEIGHT_RST = GRID_W'(256);
    localparam logic signed [ODDS_W-1:0] THRESHOLD_RST   = '0;
    localparam logic [CS_W-1:0]          CELL_SIZE_RST   = CS_W'(50);

    typedef enum logic [1:0] {
        CFG_GRID_WIDTH  = 2'd0,
        CFG_GRID_HEIGHT = 2'd1,
        CFG_THRESHOLD   = 2'd2,
        CFG_CELL_SIZE   = 2'd3
    } t_cfg_idx;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } t_cmd;

    typedef struct packed {
        logic                        cmd;
        logic [CRD_IN_W-1:0]         cell_x;
        logic [CRD_IN_W-1:0]         cell_y;
        logic signed [ODDS_W-1:0]    log_odds;
    } t_in_item;

    typedef struct packed {
        logic [DIST_W-1:0] distance_mm;
        logic              no_obstacle;
    } t_out_item;

    // Scan unit status toward the controller.
    typedef struct packed {
        logic             done;
        logic             found;
        logic [SUM_W-1:0] best;
    } t_scan_stat;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ROOT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {
        R_IDLE,
        R_SQUARE,
        R_SCALE,
        R_ITER
    } t_root_state;

endpackage

FILE: hdl/nearest_obstacle_distance_unit.sv
// ============================================================================
// nearest_obstacle_distance_unit
// Occupancy grid store with an exact nearest obstacle distance query.
// ============================================================================
// A write item gives no result. A query sweeps the configured grid_width x
// grid_height area of the grid store at one cell per cycle through the single
// read port of the store: the sweep, a read and compare pipeline, squaring
// and scaling by the cell size, the square root unit (only when an obstacle is
// found) and the output register. The store needs no clearing after reset;
// every cell must be written before a query covers it. Input is taken while
// an earlier result waits in the output register.
module nearest_obstacle_distance_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  nod_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output nod_pkg::t_out_item            o_out,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_idx,
    input  logic [nod_pkg::CFG_W-1:0]     i_cfg_data
);
    import nod_pkg::*;

    t_state                   r_state, n_state;
    logic [GRID_W-1:0]        r_grid_width;
    logic [GRID_W-1:0]        r_grid_height;
    logic signed [ODDS_W-1:0] r_thr;
    logic [CS_W-1:0]          r_cell_size;
    logic                     r_out_valid;
    t_out_item                r_out;
    t_out_item                r_res;

    logic                     in_accept, out_free, in_store;
    logic                     mem_we, scan_start, root_start, out_load;
    logic [W_W-1:0]           w_eff;
    logic [H_W-1:0]           h_eff;
    logic [ADDR_W-1:0]        waddr, raddr;
    logic [ODDS_W-1:0]        rdata;
    t_scan_stat               scan_stat;
    logic                     root_done;
    logic [ROOT_W-1:0]        root;

    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign in_store  = (32'(i_in.cell_x) < MAX_WIDTH) && (32'(i_in.cell_y) < MAX_HEIGHT);
    assign waddr     = {Y_W'(i_in.cell_y), X_W'(i_in.cell_x)};
    assign w_eff     = (32'(r_grid_width) > MAX_WIDTH) ? W_W'(MAX_WIDTH) : W_W'(r_grid_width);
    assign h_eff     = (32'(r_grid_height) > MAX_HEIGHT) ? H_W'(MAX_HEIGHT)
                                                         : H_W'(r_grid_height);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && i_in.cmd == CMD_QUERY) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (scan_stat.done) n_state = scan_stat.found ? S_ROOT : S_DONE;
            end
            S_ROOT: begin
                if (root_done) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        mem_we     = 1'b0;
        scan_start = 1'b0;
        root_start = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                mem_we     = in_accept && i_in.cmd == CMD_WRITE && in_store;
                scan_start = in_accept && i_in.cmd == CMD_QUERY;
            end
            S_SCAN: root_start = scan_stat.done && scan_stat.found;
            S_DONE: out_load = out_free;
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_out_valid   <= 1'b0;
            r_grid_width  <= GRID_WIDTH_RST;
            r_grid_height <= GRID_HEIGHT_RST;
            r_thr         <= THRESHOLD_RST;
            r_cell_size   <= CELL_SIZE_RST;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_GRID_WIDTH:  r_grid_width  <= i_cfg_data[GRID_W-1:0];
                    CFG_GRID_HEIGHT: r_grid_height <= i_cfg_data[GRID_W-1:0];
                    CFG_THRESHOLD:   r_thr         <= $signed(i_cfg_data[ODDS_W-1:0]);
                    CFG_CELL_SIZE:   r_cell_size   <= i_cfg_data[CS_W-1:0];
                    default:         r_thr         <= r_thr;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN && scan_stat.done && !scan_stat.found) begin
            r_res.distance_mm <= DIST_W'(NO_OBSTACLE_MM);
            r_res.no_obstacle <= 1'b1;
        end else if (r_state == S_ROOT && root_done) begin
            r_res.distance_mm <= (32'(root) > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(root);
            r_res.no_obstacle <= 1'b0;
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    nod_ram #(
        .DATA_W (ODDS_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (waddr),
        .i_wdata (i_in.log_odds),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nod_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_qx    (i_in.cell_x),
        .i_qy    (i_in.cell_y),
        .i_w     (w_eff),
        .i_h     (h_eff),
        .i_thr   (r_thr),
        .o_raddr (raddr),
        .i_rdata (rdata),
        .o_stat  (scan_stat)
    );

    nod_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_cs    (r_cell_size),
        .i_best  (scan_stat.best),
        .o_done  (root_done),
        .o_root  (root)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

FILE: hdl/nod_ram.sv
// ============================================================================
// nod_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
module nod_ram #(
    parameter int DATA_W = 8,
    parameter int ADDR_W = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [0:(1 << ADDR_W)-1];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/nod_scan.sv
// ============================================================================
// nod_scan
// Sweeps the grid store one cell per cycle and keeps the smallest squared
// distance from the query cell to any obstacle cell.
// ============================================================================
module nod_scan (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [nod_pkg::CRD_IN_W-1:0]      i_qx,
    input  logic [nod_pkg::CRD_IN_W-1:0]      i_qy,
    input  logic [nod_pkg::W_W-1:0]           i_w,
    input  logic [nod_pkg::H_W-1:0]           i_h,
    input  logic signed [nod_pkg::ODDS_W-1:0] i_thr,
    output logic [nod_pkg::ADDR_W-1:0]        o_raddr,
    input  logic [nod_pkg::ODDS_W-1:0]        i_rdata,
    output nod_pkg::t_scan_stat               o_stat
);
    import nod_pkg::*;

    logic                     r_busy;
    logic                     r_issuing;
    logic [X_W-1:0]           r_x;
    logic [Y_W-1:0]           r_y;
    logic [W_W-1:0]           r_w;
    logic [H_W-1:0]           r_h;
    logic [CRD_IN_W-1:0]      r_qx;
    logic [CRD_IN_W-1:0]      r_qy;
    logic signed [ODDS_W-1:0] r_thr;

    logic                     r_v1, r_v2, r_v3;
    logic [X_W-1:0]           r_s1_x;
    logic [Y_W-1:0]           r_s1_y;
    logic                     r_s2_hit;
    logic [CRD_W-1:0]         r_s2_dx, r_s2_dy;
    logic                     r_s3_hit;
    logic [SQ_W-1:0]          r_s3_dx2, r_s3_dy2;
    logic                     r_found;
    logic [SUM_W-1:0]         r_best;

    logic                     last_x, last_y, done;
    logic [CRD_W-1:0]         ax, bx, ay, by, dx, dy;
    logic                     hit;
    logic [SUM_W-1:0]         sum;

    assign last_x  = (32'(r_x) + 1) == 32'(r_w);
    assign last_y  = (32'(r_y) + 1) == 32'(r_h);
    assign o_raddr = {r_y, r_x};
    assign done    = r_busy && !r_issuing && !r_v1 && !r_v2 && !r_v3;

    always_comb begin
        ax  = CRD_W'(r_s1_x);
        bx  = CRD_W'(r_qx);
        ay  = CRD_W'(r_s1_y);
        by  = CRD_W'(r_qy);
        dx  = (ax > bx) ? (ax - bx) : (bx - ax);
        dy  = (ay > by) ? (ay - by) : (by - ay);
        hit = $signed(i_rdata) >= r_thr;
        sum = SUM_W'(r_s3_dx2) + SUM_W'(r_s3_dy2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issuing <= 1'b0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_found   <= 1'b0;
        end else begin
            r_v1 <= r_issuing;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            if (done) begin
                r_busy <= 1'b0;
            end
            if (r_issuing) begin
                if (last_x) begin
                    r_x <= '0;
                    r_y <= r_y + 1'b1;
                    if (last_y) begin
                        r_issuing <= 1'b0;
                    end
                end else begin
                    r_x <= r_x + 1'b1;
                end
            end
            if (r_v3 && r_s3_hit && (!r_found || sum < r_best)) begin
                r_best  <= sum;
                r_found <= 1'b1;
            end
            if (i_start) begin
                r_busy    <= 1'b1;
                r_issuing <= (i_w != '0) && (i_h != '0);
                r_x       <= '0;
                r_y       <= '0;
                r_w       <= i_w;
                r_h       <= i_h;
                r_qx      <= i_qx;
                r_qy      <= i_qy;
                r_thr     <= i_thr;
                r_found   <= 1'b0;
            end
        end
    end

    // Read data arrives in the cycle after the address; squares are registered
    // before they are summed.
    always_ff @(posedge i_clk) begin
        r_s1_x   <= r_x;
        r_s1_y   <= r_y;
        r_s2_hit <= hit;
        r_s2_dx  <= dx;
        r_s2_dy  <= dy;
        r_s3_hit <= r_s2_hit;
        r_s3_dx2 <= SQ_W'(r_s2_dx) * SQ_W'(r_s2_dx);
        r_s3_dy2 <= SQ_W'(r_s2_dy) * SQ_W'(r_s2_dy);
    end

    assign o_stat.done  = done;
    assign o_stat.found = r_found;
    assign o_stat.best  = r_best;

`ifndef SYNTHESIS
    a_addr_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_issuing |-> (32'(r_x) < 32'(r_w)) && (32'(r_y) < 32'(r_h)))
        else $error("scan address outside the configured grid");

    a_done_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (done && !i_start) |=> !r_busy)
        else $error("scan still busy after done");

    a_found_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!(r_v3 && r_s3_hit) && !i_start) |=> $stable(r_found))
        else $error("found flag changed without an obstacle hit");
`endif

endmodule

FILE: hdl/nod_isqrt.sv
// ============================================================================
// nod_isqrt
// Scales the squared cell distance by the squared cell size and takes the
// integer square root, two radicand bits per cycle.
// ============================================================================
module nod_isqrt (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [nod_pkg::CS_W-1:0]     i_cs,
    input  logic [nod_pkg::SUM_W-1:0]    i_best,
    output logic                         o_done,
    output logic [nod_pkg::ROOT_W-1:0]   o_root
);
    import nod_pkg::*;

    t_root_state        r_state, n_state;
    logic [CS_W-1:0]    r_cs;
    logic [SUM_W-1:0]   r_best;
    logic [CS2_W-1:0]   r_cs2;
    logic [RAD_W-1:0]   r_rad;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [CNT_W-1:0]   r_cnt;

    logic [REM_W-1:0]   rem_sh, trial;
    logic               take;

    always_comb begin
        n_state = r_state;
        case (r_state)
            R_IDLE:   if (i_start) n_state = R_SQUARE;
            R_SQUARE: n_state = R_SCALE;
            R_SCALE:  n_state = R_ITER;
            R_ITER:   if (r_cnt == CNT_W'(1)) n_state = R_IDLE;
            default:  n_state = R_IDLE;
        endcase
    end

    always_comb begin
        o_done = 1'b0;
        case (r_state)
            R_ITER:  o_done = (r_cnt == CNT_W'(1));
            default: o_done = 1'b0;
        endcase
    end

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {r_root, 2'b01};
        take   = rem_sh >= trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= R_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            R_IDLE: begin
                r_cs   <= i_cs;
                r_best <= i_best;
            end
            R_SQUARE: begin
                r_cs2 <= CS2_W'(r_cs) * CS2_W'(r_cs);
            end
            R_SCALE: begin
                r_rad  <= RAD_W'(r_cs2) * RAD_W'(r_best);
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(ROOT_W);
            end
            R_ITER: begin
                r_rad  <= r_rad << 2;
                r_cnt  <= r_cnt - 1'b1;
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[ROOT_W-2:0], take};
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    // The final root bit is formed in the same cycle that done is raised.
    assign o_root = {r_root[ROOT_W-2:0], take};

`ifndef SYNTHESIS
    a_iter_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == R_ITER) |-> (r_cnt != '0))
        else $error("root iteration count ran out");
`endif

endmodule
